[rtl/rvx_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvx_pkg
// Shared types, opcode classes and encoding constants of the execute stage.
// ----------------------------------------------------------------------------
package rvx_pkg;

    localparam int XLEN  = 64;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [3:0] {
        OPC_LUI    = 4'd0,
        OPC_AUIPC  = 4'd1,
        OPC_JAL    = 4'd2,
        OPC_JALR   = 4'd3,
        OPC_BRANCH = 4'd4,
        OPC_OPIMM  = 4'd5,
        OPC_OPIMM32 = 4'd6,
        OPC_OP     = 4'd7,
        OPC_OP32   = 4'd8
    } t_opc;

    // operation kinds chosen by the front part
    typedef enum logic [4:0] {
        K_ADD, K_SUB, K_SLL, K_SLT, K_SLTU, K_XOR, K_SRL, K_SRA, K_OR, K_AND,
        K_MUL, K_MULH, K_MULHSU, K_MULHU, K_DIV, K_DIVU, K_REM, K_REMU,
        K_PASSB, K_LINK, K_BRANCH, K_ILLEGAL
    } t_kind;

    // execute-side sequencer states
    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} t_state;

    localparam logic [6:0] F7_ALT    = 7'h20;
    localparam logic [6:0] F7_MULDIV = 7'h01;
    localparam logic [5:0] F6_SRAI   = 6'h10;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    // classified item between the two halves
    typedef struct packed {
        t_kind       kind;
        logic        word;
        logic [2:0]  cond;
        logic [4:0]  rd;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] pc;
        logic [63:0] seq;
        logic [63:0] target;
        logic        wr;
    } t_uop;

    function automatic logic [63:0] sx32(input logic [63:0] v);
        sx32 = {{32{v[31]}}, v[31:0]};
    endfunction

endpackage
`default_nettype wire

[rtl/rv64im_integer_execute.sv]
// alu, jump and branch items go from the queue through the combinational alu into the
// output register; multiplies use a partial-product unit and a sum step, divides a
// 64-step radix-2 divider, and both hold the back part until their result is loaded
// throughput: one alu, jump or branch item per cycle while the output is not stalled
// a 4-entry queue decouples decode from execution
// synchronous active-low reset empties the queue and the output register
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rv64im_integer_execute
// RV64IM integer execute stage: decode front, queue, execute back.
// ----------------------------------------------------------------------------
module rv64im_integer_execute #(
    parameter int QDEPTH = rvx_pkg::QUEUE_DEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // opcode[3:0] funct3[6:4] funct7[13:7] shamt[19:14] dest_index[24:20]
    // src1_value[88:25] src2_value[152:89] immediate[184:153] cur_pc[248:185]
    // insn_length[251:249]
    input  wire logic [255:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // write_index[4:0] write_enable[5] write_value[69:6] next_pc[133:70]
    // illegal[134]
    output logic [135:0]      m_axis_tdata
);
    import rvx_pkg::*;

    t_uop fu, qu;
    logic full, empty, pop;
    logic [4:0]  rd;
    logic        we, ill;
    logic [63:0] val, npc;

    rvx_front u_front (
        .i_opcode(s_axis_tdata[3:0]), .i_funct3(s_axis_tdata[6:4]),
        .i_funct7(s_axis_tdata[13:7]), .i_shamt(s_axis_tdata[19:14]),
        .i_dest_index(s_axis_tdata[24:20]), .i_src1_value(s_axis_tdata[88:25]),
        .i_src2_value(s_axis_tdata[152:89]), .i_immediate(s_axis_tdata[184:153]),
        .i_cur_pc(s_axis_tdata[248:185]), .i_insn_length(s_axis_tdata[251:249]),
        .o_uop(fu)
    );

    assign s_axis_tready = !full;

    rvx_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(s_axis_tvalid && !full), .i_data(fu), .o_full(full),
        .i_pop(pop), .o_data(qu), .o_empty(empty)
    );

    rvx_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_uop(qu), .i_valid(!empty),
        .o_pop(pop), .o_tvalid(m_axis_tvalid), .i_tready(m_axis_tready),
        .o_rd(rd), .o_we(we), .o_val(val), .o_npc(npc), .o_ill(ill)
    );

    assign m_axis_tdata = {1'b0, ill, npc, val, we, rd};

`ifndef SYNTH
    a_illegal_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(ill && we)) else $error("illegal item writes");
    a_x0_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && rd == 5'd0) |-> !we) else $error("write to x0");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty) else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

[rtl/rvx_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvx_front
// Decodes an item into an operation kind with its operands and targets.
// ----------------------------------------------------------------------------
module rvx_front (
    input  wire logic [3:0]  i_opcode,
    input  wire logic [2:0]  i_funct3,
    input  wire logic [6:0]  i_funct7,
    input  wire logic [5:0]  i_shamt,
    input  wire logic [4:0]  i_dest_index,
    input  wire logic [63:0] i_src1_value,
    input  wire logic [63:0] i_src2_value,
    input  wire logic [31:0] i_immediate,
    input  wire logic [63:0] i_cur_pc,
    input  wire logic [2:0]  i_insn_length,
    output rvx_pkg::t_uop    o_uop
);
    import rvx_pkg::*;

    logic [63:0] imm;
    logic [63:0] seq;
    logic [63:0] pc_imm;
    t_kind       kind;
    logic        word;
    logic        use_imm;
    logic [63:0] opb;

    assign imm    = {{32{i_immediate[31]}}, i_immediate};
    assign seq    = i_cur_pc + {61'd0, i_insn_length};
    assign pc_imm = i_cur_pc + imm;

    always_comb begin
        kind    = K_ILLEGAL;
        word    = 1'b0;
        use_imm = 1'b1;
        case (i_opcode)
            OPC_LUI:   kind = K_PASSB;
            OPC_AUIPC: kind = K_PASSB;
            OPC_JAL:   kind = K_LINK;
            OPC_JALR:  kind = (i_funct3 == F3_ADD) ? K_LINK : K_ILLEGAL;
            OPC_BRANCH: begin
                use_imm = 1'b0;
                kind = (i_funct3 == 3'd2 || i_funct3 == 3'd3) ? K_ILLEGAL : K_BRANCH;
            end
            OPC_OPIMM: begin
                case (i_funct3)
                    F3_ADD:  kind = K_ADD;
                    F3_SLL:  kind = (i_funct7[6:1] == 6'd0) ? K_SLL : K_ILLEGAL;
                    F3_SLT:  kind = K_SLT;
                    F3_SLTU: kind = K_SLTU;
                    F3_XOR:  kind = K_XOR;
                    F3_SR: begin
                        if (i_funct7[6:1] == F6_SRAI) kind = K_SRA;
                        else if (i_funct7[6:1] == 6'd0) kind = K_SRL;
                        else kind = K_ILLEGAL;
                    end
                    F3_OR:   kind = K_OR;
                    default: kind = K_AND;
                endcase
            end
            OPC_OPIMM32: begin
                word = 1'b1;
                if (i_funct3 == F3_ADD) kind = K_ADD;
                else if (i_funct3 == F3_SLL && i_funct7 == 7'd0) kind = K_SLL;
                else if (i_funct3 == F3_SR && i_funct7 == 7'd0) kind = K_SRL;
                else if (i_funct3 == F3_SR && i_funct7 == F7_ALT) kind = K_SRA;
                else kind = K_ILLEGAL;
            end
            OPC_OP, OPC_OP32: begin
                use_imm = 1'b0;
                word    = (i_opcode == OPC_OP32);
                if (i_funct7 == F7_MULDIV) begin
                    case (i_funct3)
                        3'd0:    kind = K_MUL;
                        3'd1:    kind = word ? K_ILLEGAL : K_MULH;
                        3'd2:    kind = word ? K_ILLEGAL : K_MULHSU;
                        3'd3:    kind = word ? K_ILLEGAL : K_MULHU;
                        3'd4:    kind = K_DIV;
                        3'd5:    kind = K_DIVU;
                        3'd6:    kind = K_REM;
                        default: kind = K_REMU;
                    endcase
                end else if (i_funct7 == 7'd0) begin
                    case (i_funct3)
                        F3_ADD:  kind = K_ADD;
                        F3_SLL:  kind = K_SLL;
                        F3_SLT:  kind = word ? K_ILLEGAL : K_SLT;
                        F3_SLTU: kind = word ? K_ILLEGAL : K_SLTU;
                        F3_XOR:  kind = word ? K_ILLEGAL : K_XOR;
                        F3_SR:   kind = K_SRL;
                        F3_OR:   kind = word ? K_ILLEGAL : K_OR;
                        default: kind = word ? K_ILLEGAL : K_AND;
                    endcase
                end else if (i_funct7 == F7_ALT && i_funct3 == F3_ADD) begin
                    kind = K_SUB;
                end else if (i_funct7 == F7_ALT && i_funct3 == F3_SR) begin
                    kind = K_SRA;
                end else begin
                    kind = K_ILLEGAL;
                end
            end
            default: kind = K_ILLEGAL;
        endcase
    end

    // immediate shifts carry their amount in the low bits of b
    always_comb begin
        opb = use_imm ? imm : i_src2_value;
        if ((i_opcode == OPC_OPIMM || i_opcode == OPC_OPIMM32)
                && (i_funct3 == F3_SLL || i_funct3 == F3_SR))
            opb = {58'd0, i_shamt};
        if (i_opcode == OPC_AUIPC)
            opb = pc_imm;
    end

    always_comb begin
        o_uop.kind = kind;
        o_uop.word = word;
        o_uop.cond = i_funct3;
        o_uop.rd   = i_dest_index;
        o_uop.a    = i_src1_value;
        o_uop.b    = opb;
        o_uop.pc   = i_cur_pc;
        o_uop.seq  = seq;
        o_uop.target = (i_opcode == OPC_JALR)
            ? ((i_src1_value + imm) & ~64'd1) : pc_imm;
        o_uop.wr   = (kind != K_ILLEGAL) && (kind != K_BRANCH)
            && (i_dest_index != 5'd0);
    end

endmodule
`default_nettype wire

[rtl/rvx_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvx_queue
// Small register queue between the decode and execute halves.
// ----------------------------------------------------------------------------
module rvx_queue #(
    parameter int DEPTH = rvx_pkg::QUEUE_DEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  rvx_pkg::t_uop     i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output rvx_pkg::t_uop     o_data,
    output logic              o_empty
);
    import rvx_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_uop          r_mem [DEPTH];
    logic [AW-1:0] r_wp, n_wp;
    logic [AW-1:0] r_rp, n_rp;
    logic [AW:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        n_cnt = r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule
`default_nettype wire

[rtl/rvx_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvx_back
// Executes one item: combinational alu, partial-product multiplier, radix-2 divider.
// ----------------------------------------------------------------------------
module rvx_back (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  rvx_pkg::t_uop    i_uop,
    input  wire logic        i_valid,
    output logic             o_pop,
    output logic             o_tvalid,
    input  wire logic        i_tready,
    output logic [4:0]       o_rd,
    output logic             o_we,
    output logic [63:0]      o_val,
    output logic [63:0]      o_npc,
    output logic             o_ill
);
    import rvx_pkg::*;

    t_state r_st, n_st;
    t_uop   r_u;
    logic   r_ov;
    logic [4:0]  r_rd;
    logic        r_we;
    logic [63:0] r_val, r_npc;
    logic        r_ill;

    // mul: four 32x32 partial products, then sum
    logic [63:0] r_ma, r_mb;
    logic [63:0] r_p00, r_p01, r_p10, r_p11;
    logic [1:0]  r_mstep;
    // div
    logic [63:0] r_q, r_rem, r_dvs;
    logic [6:0]  r_dcnt;
    logic        r_qneg, r_rneg;

    logic        is_mul, is_div, take, slt, sltu;
    logic [63:0] a, b, alu;
    logic [5:0]  sh;
    logic [63:0] a32s;
    logic        can_load;

    assign a  = i_uop.a;
    assign b  = i_uop.b;
    assign sh = i_uop.word ? {1'b0, b[4:0]} : b[5:0];
    assign a32s = sx32(a);
    assign slt  = $signed(a) < $signed(b);
    assign sltu = a < b;
    assign is_mul = (i_uop.kind == K_MUL) || (i_uop.kind == K_MULH)
        || (i_uop.kind == K_MULHSU) || (i_uop.kind == K_MULHU);
    assign is_div = (i_uop.kind == K_DIV) || (i_uop.kind == K_DIVU)
        || (i_uop.kind == K_REM) || (i_uop.kind == K_REMU);

    always_comb begin
        case (i_uop.cond)
            F3_BEQ:  take = (a == b);
            F3_BNE:  take = (a != b);
            F3_BLT:  take = slt;
            F3_BGE:  take = !slt;
            F3_BLTU: take = sltu;
            default: take = !sltu;
        endcase
    end

    always_comb begin
        case (i_uop.kind)
            K_ADD:   alu = a + b;
            K_SUB:   alu = a - b;
            K_SLL:   alu = a << sh;
            K_SLT:   alu = {63'd0, slt};
            K_SLTU:  alu = {63'd0, sltu};
            K_XOR:   alu = a ^ b;
            K_SRL:   alu = i_uop.word ? ({32'd0, a[31:0]} >> sh) : (a >> sh);
            K_SRA:   alu = i_uop.word ? 64'($signed(a32s) >>> sh)
                                      : 64'($signed(a) >>> sh);
            K_OR:    alu = a | b;
            K_AND:   alu = a & b;
            K_PASSB: alu = b;
            K_LINK:  alu = i_uop.seq;
            default: alu = '0;
        endcase
        if (i_uop.word) alu = sx32(alu);
    end

    // result register is free when empty or being taken
    assign can_load = !o_tvalid || i_tready;

    // divider operand prep
    logic        sgn, an, bn;
    logic [63:0] da, db, ma, mb;
    always_comb begin
        sgn = (i_uop.kind == K_DIV) || (i_uop.kind == K_REM);
        da = i_uop.word ? (sgn ? a32s : {32'd0, a[31:0]}) : a;
        db = i_uop.word ? (sgn ? sx32(b) : {32'd0, b[31:0]}) : b;
        an = sgn && da[63];
        bn = sgn && db[63];
        ma = an ? -da : da;
        mb = bn ? -db : db;
    end

    // mul sums
    logic [127:0] prod;
    logic [63:0]  hu, mres;
    assign prod = {r_p11, 64'd0} + {32'd0, r_p01, 32'd0} + {32'd0, r_p10, 32'd0}
        + {64'd0, r_p00};
    assign hu = prod[127:64];

    logic [64:0] dtry;
    logic [63:0] dsh;
    assign dsh  = {r_rem[62:0], r_q[63]};
    assign dtry = {r_rem, r_q[63]} - {1'b0, r_dvs};

    logic [63:0] dq, dr, dres;

    always_comb begin
        case (r_u.kind)
            K_MULH:   mres = hu - (r_ma[63] ? r_mb : 64'd0) - (r_mb[63] ? r_ma : 64'd0);
            K_MULHSU: mres = hu - (r_ma[63] ? r_mb : 64'd0);
            K_MULHU:  mres = hu;
            default:  mres = prod[63:0];
        endcase
        if (r_u.word) mres = sx32(mres);
        dq = r_qneg ? -r_q : r_q;
        dr = r_rneg ? -r_rem : r_rem;
        if (r_dvs == 64'd0) begin
            dq = '1;
            dr = r_ma;
        end
        if (r_ov) begin
            dq = r_ma;
            dr = '0;
        end
        dres = ((r_u.kind == K_REM) || (r_u.kind == K_REMU)) ? dr : dq;
        if (r_u.word) dres = sx32(dres);
    end

    always_comb begin
        n_st  = r_st;
        o_pop = 1'b0;
        case (r_st)
            S_IDLE: begin
                if (i_valid) begin
                    if (is_mul) begin
                        o_pop = 1'b1;
                        n_st  = S_MUL;
                    end else if (is_div) begin
                        o_pop = 1'b1;
                        n_st  = S_DIV;
                    end else if (can_load) begin
                        o_pop = 1'b1;
                    end
                end
            end
            S_MUL:  if (r_mstep == 2'd2) n_st = S_FIN;
            S_DIV:  if (r_dcnt == 7'd0) n_st = S_FIN;
            S_FIN:  if (can_load) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            o_tvalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (can_load) begin
                o_tvalid <= (r_st == S_FIN)
                    || ((r_st == S_IDLE) && o_pop && !is_mul && !is_div);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_st == S_IDLE) && o_pop && !is_mul && !is_div) begin
            r_rd  <= i_uop.rd;
            r_ill <= (i_uop.kind == K_ILLEGAL);
            r_we  <= i_uop.wr;
            r_val <= i_uop.wr ? alu : 64'd0;
            if (i_uop.kind == K_ILLEGAL)
                r_npc <= i_uop.pc;
            else if (i_uop.kind == K_LINK || (i_uop.kind == K_BRANCH && take))
                r_npc <= i_uop.target;
            else
                r_npc <= i_uop.seq;
        end else if ((r_st == S_FIN) && can_load) begin
            r_rd  <= r_u.rd;
            r_ill <= 1'b0;
            r_we  <= r_u.wr;
            r_val <= r_u.wr ? ((r_u.kind == K_MUL || r_u.kind == K_MULH
                || r_u.kind == K_MULHSU || r_u.kind == K_MULHU) ? mres : dres) : 64'd0;
            r_npc <= r_u.seq;
        end
    end

    // long-op datapath
    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE && o_pop && (is_mul || is_div)) begin
            r_u     <= i_uop;
            r_mstep <= 2'd0;
            r_dcnt  <= 7'd64;
            if (is_mul) begin
                r_ma <= a;
                r_mb <= b;
            end else begin
                r_ma   <= da;
                r_q    <= ma;
                r_rem  <= '0;
                r_dvs  <= mb;
                r_qneg <= an ^ bn;
                r_rneg <= an;
                r_ov   <= sgn && (i_uop.word ? (da == sx32(64'h80000000))
                                             : (da == {1'b1, 63'd0}))
                          && (db == '1);
            end
        end else if (r_st == S_MUL) begin
            r_mstep <= r_mstep + 2'd1;
            case (r_mstep)
                2'd0: begin
                    r_p00 <= {32'd0, r_ma[31:0]} * {32'd0, r_mb[31:0]};
                    r_p01 <= {32'd0, r_ma[31:0]} * {32'd0, r_mb[63:32]};
                end
                default: begin
                    r_p10 <= {32'd0, r_ma[63:32]} * {32'd0, r_mb[31:0]};
                    r_p11 <= {32'd0, r_ma[63:32]} * {32'd0, r_mb[63:32]};
                end
            endcase
        end else if (r_st == S_DIV && r_dcnt != 7'd0) begin
            r_dcnt <= r_dcnt - 7'd1;
            if (!dtry[64]) begin
                r_rem <= dtry[63:0];
                r_q   <= {r_q[62:0], 1'b1};
            end else begin
                r_rem <= dsh;
                r_q   <= {r_q[62:0], 1'b0};
            end
        end
    end

    assign o_rd  = r_rd;
    assign o_we  = r_we;
    assign o_val = r_val;
    assign o_npc = r_npc;
    assign o_ill = r_ill;

endmodule
`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the RV64IM execute stage: directed corner instructions, then random
// instruction streams with random stalls on both stream sides, each result
// compared against a behavioral execute model or a typed-in expected item.
// ----------------------------------------------------------------------------
module tb_top;
    import rvx_pkg::*;

    typedef struct {
        logic [3:0]  opc;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [5:0]  sh;
        logic [4:0]  rd;
        logic [63:0] a;
        logic [63:0] b;
        logic [31:0] imm;
        logic [63:0] pc;
        logic [2:0]  len;
    } insn_t;

    typedef struct packed {
        logic        ill;
        logic [63:0] npc;
        logic [63:0] val;
        logic        we;
        logic [4:0]  rd;
    } wb_t;

    // one row of the directed table; fixed rows carry their expected item
    typedef struct {
        insn_t t;
        bit    fixed;
        wb_t   exp;
    } row_t;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [255:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;

    rv64im_integer_execute dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    wb_t    wb_expected[$];
    int     n_mismatch = 0;
    bit     drive_done = 0;
    bit     hold_sink  = 0;
    localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ONES  = '1;

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [63:0] sx(input logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

    function automatic logic [63:0] sdiv(input logic [63:0] x, input logic [63:0] y,
                                         input bit rem);
        logic [63:0] mx, my, r;
        mx = x[63] ? -x : x;
        my = y[63] ? -y : y;
        if (y == 0) return rem ? x : ONES;
        if (rem) begin
            r = mx % my;
            return x[63] ? -r : r;
        end
        r = mx / my;
        return (x[63] ^ y[63]) ? -r : r;
    endfunction

    function automatic logic [63:0] udiv(input logic [63:0] x, input logic [63:0] y,
                                         input bit rem);
        if (y == 0) return rem ? x : ONES;
        return rem ? x % y : x / y;
    endfunction

    function automatic wb_t execute(input insn_t t);
        wb_t         r;
        logic [63:0] imm, seq, npc, v, hu, a, b;
        logic [127:0] pp;
        bit          wr, ill, take;
        a = t.a; b = t.b;
        imm = {{32{t.imm[31]}}, t.imm};
        seq = t.pc + 64'(t.len);
        npc = seq; v = 0; wr = 0; ill = 0; take = 0;
        case (t.opc)
            OPC_LUI: begin v = imm; wr = 1; end
            OPC_AUIPC: begin v = t.pc + imm; wr = 1; end
            OPC_JAL: begin v = seq; wr = 1; npc = t.pc + imm; end
            OPC_JALR: begin
                if (t.f3 != 0) ill = 1;
                else begin
                    v = seq; wr = 1; npc = (a + imm) & ~64'd1;
                end
            end
            OPC_BRANCH: begin
                case (t.f3)
                    F3_BEQ:  take = a == b;
                    F3_BNE:  take = a != b;
                    F3_BLT:  take = $signed(a) < $signed(b);
                    F3_BGE:  take = !($signed(a) < $signed(b));
                    F3_BLTU: take = a < b;
                    F3_BGEU: take = a >= b;
                    default: ill = 1;
                endcase
                if (take) npc = t.pc + imm;
            end
            OPC_OPIMM: begin
                wr = 1;
                case (t.f3)
                    F3_ADD: v = a + imm;
                    F3_SLL: if (t.f7[6:1] != 0) ill = 1; else v = a << t.sh;
                    F3_SLT: v = 64'($signed(a) < $signed(imm));
                    F3_SLTU: v = 64'(a < imm);
                    F3_XOR: v = a ^ imm;
                    F3_SR: begin
                        if (t.f7[6:1] == F6_SRAI) v = $signed(a) >>> t.sh;
                        else if (t.f7[6:1] == 0) v = a >> t.sh;
                        else ill = 1;
                    end
                    F3_OR: v = a | imm;
                    default: v = a & imm;
                endcase
            end
            OPC_OPIMM32: begin
                wr = 1;
                if (t.f3 == F3_ADD) v = sx(a + imm);
                else if (t.f3 == F3_SLL && t.f7 == 0) v = sx(a << t.sh[4:0]);
                else if (t.f3 == F3_SR && t.f7 == 0) v = sx({32'd0, a[31:0]} >> t.sh[4:0]);
                else if (t.f3 == F3_SR && t.f7 == F7_ALT)
                    v = sx($signed(sx(a)) >>> t.sh[4:0]);
                else ill = 1;
            end
            OPC_OP: begin
                wr = 1;
                if (t.f7 == F7_MULDIV) begin
                    pp = {64'd0, a} * {64'd0, b};
                    hu = pp[127:64];
                    case (t.f3)
                        3'd0: v = pp[63:0];
                        3'd1: v = hu - (a[63] ? b : 0) - (b[63] ? a : 0);
                        3'd2: v = hu - (a[63] ? b : 0);
                        3'd3: v = hu;
                        3'd4: v = sdiv(a, b, 0);
                        3'd5: v = udiv(a, b, 0);
                        3'd6: v = sdiv(a, b, 1);
                        default: v = udiv(a, b, 1);
                    endcase
                end else if (t.f7 == 0) begin
                    case (t.f3)
                        F3_ADD: v = a + b;
                        F3_SLL: v = a << b[5:0];
                        F3_SLT: v = 64'($signed(a) < $signed(b));
                        F3_SLTU: v = 64'(a < b);
                        F3_XOR: v = a ^ b;
                        F3_SR: v = a >> b[5:0];
                        F3_OR: v = a | b;
                        default: v = a & b;
                    endcase
                end else if (t.f7 == F7_ALT && t.f3 == F3_ADD) v = a - b;
                else if (t.f7 == F7_ALT && t.f3 == F3_SR) v = $signed(a) >>> b[5:0];
                else ill = 1;
            end
            OPC_OP32: begin
                wr = 1;
                if (t.f7 == F7_MULDIV) begin
                    case (t.f3)
                        3'd0: v = sx(a * b);
                        3'd4: v = (b[31:0] == 0) ? ONES : sx(sdiv(sx(a), sx(b), 0));
                        3'd5: v = (b[31:0] == 0) ? ONES
                                  : sx(udiv({32'd0, a[31:0]}, {32'd0, b[31:0]}, 0));
                        3'd6: v = (b[31:0] == 0) ? sx(a) : sx(sdiv(sx(a), sx(b), 1));
                        3'd7: v = sx(udiv({32'd0, a[31:0]}, {32'd0, b[31:0]}, 1));
                        default: ill = 1;
                    endcase
                end else if (t.f7 == 0) begin
                    if (t.f3 == F3_ADD) v = sx(a + b);
                    else if (t.f3 == F3_SLL) v = sx(a << b[4:0]);
                    else if (t.f3 == F3_SR) v = sx({32'd0, a[31:0]} >> b[4:0]);
                    else ill = 1;
                end else if (t.f7 == F7_ALT) begin
                    if (t.f3 == F3_ADD) v = sx(a - b);
                    else if (t.f3 == F3_SR) v = sx($signed(sx(a)) >>> b[4:0]);
                    else ill = 1;
                end else ill = 1;
            end
            default: ill = 1;
        endcase
        if (ill) begin
            wr = 0; npc = t.pc;
        end
        if (t.rd == 0) wr = 0;
        if (!wr) v = 0;
        r.rd = t.rd; r.we = wr; r.val = v; r.npc = npc; r.ill = ill;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        logic [63:0] x;
        x = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: x = 0;
            1: x = ONES;
            2: x = MIN64;
            3: x = sx(x);
            4: x = 64'($urandom_range(0, 40));
            default: ;
        endcase
        return x;
    endfunction

    function automatic insn_t rand_insn();
        insn_t t;
        logic [6:0] f7s[5] = '{7'h00, F7_MULDIV, F7_ALT, 7'h21, 7'h00};
        t.opc = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(9, 15))
                                             : 4'($urandom_range(0, 8));
        t.f3  = 3'($urandom);
        t.f7  = ($urandom_range(0, 5) == 0) ? 7'($urandom) : f7s[$urandom_range(0, 4)];
        t.sh  = 6'($urandom);
        if (t.opc == OPC_OPIMM && t.f7 == F7_ALT) t.f7 = 7'(F6_SRAI << 1) | 7'($urandom_range(0, 1));
        t.rd  = 5'($urandom);
        t.a   = rand64();
        t.b   = ($urandom_range(0, 3) == 0) ? t.a : rand64();
        t.imm = ($urandom_range(0, 3) == 0) ? 32'(rand64()) : $urandom;
        t.pc  = rand64();
        t.len = ($urandom_range(0, 7) == 0) ? 3'($urandom) : ($urandom_range(0, 1) ? 3'd4 : 3'd2);
        return t;
    endfunction

    function automatic insn_t mk(input logic [3:0] o, input logic [2:0] f3,
                                 input logic [6:0] f7, input logic [63:0] a,
                                 input logic [63:0] b, input logic [31:0] imm);
        insn_t t;
        t.opc = o; t.f3 = f3; t.f7 = f7; t.sh = 6'd63; t.rd = 5'd5;
        t.a = a; t.b = b; t.imm = imm; t.pc = 64'h1000; t.len = 3'd4;
        return t;
    endfunction

    // row checked against the predictor
    function automatic row_t chk(input insn_t t);
        row_t r;
        r.t = t; r.fixed = 1'b0; r.exp = '0;
        return r;
    endfunction

    // row with its expected item typed in
    function automatic row_t fix(input insn_t t, input wb_t e);
        row_t r;
        r.t = t; r.fixed = 1'b1; r.exp = e;
        return r;
    endfunction

    // send one item, with a random gap before it
    task automatic send_insn(input insn_t t, input bit fixed, input wb_t exp);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, t.len, t.pc, t.imm, t.b, t.a, t.rd, t.sh, t.f7, t.f3, t.opc};
        wb_expected.push_back(fixed ? exp : execute(t));
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    initial begin
        row_t  dir[$];
        insn_t t;
        s_axis_tvalid = 0;
        s_axis_tdata  = '0;
        i_rst_n = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // division and multiply corners, shifts, jumps, branches, LUI, illegal encodings
        dir.push_back(fix(mk(OPC_OP, 3'd4, F7_MULDIV, 64'd7, 64'd0, 0),
                          wb_t'{1'b0, 64'h1004, ONES, 1'b1, 5'd5}));
        dir.push_back(fix(mk(OPC_OP, 3'd6, F7_MULDIV, 64'd7, 64'd0, 0),
                          wb_t'{1'b0, 64'h1004, 64'd7, 1'b1, 5'd5}));
        dir.push_back(chk(mk(OPC_OP, 3'd4, F7_MULDIV, MIN64, ONES, 0)));
        dir.push_back(chk(mk(OPC_OP, 3'd6, F7_MULDIV, MIN64, ONES, 0)));
        dir.push_back(chk(mk(OPC_OP, 3'd5, F7_MULDIV, ONES, 64'd0, 0)));
        dir.push_back(chk(mk(OPC_OP, 3'd7, F7_MULDIV, ONES, 64'd0, 0)));
        dir.push_back(chk(mk(OPC_OP32, 3'd4, F7_MULDIV, 64'h8000_0000, ONES, 0)));
        dir.push_back(chk(mk(OPC_OP32, 3'd6, F7_MULDIV, 64'h8000_0000, 64'd0, 0)));
        dir.push_back(chk(mk(OPC_OP32, 3'd7, F7_MULDIV, 64'hffff_ffff, 64'd0, 0)));
        dir.push_back(chk(mk(OPC_OP32, 3'd1, F7_MULDIV, 64'd3, 64'd3, 0)));
        dir.push_back(chk(mk(OPC_OP, 3'd1, F7_MULDIV, MIN64, MIN64, 0)));
        dir.push_back(chk(mk(OPC_OP, 3'd2, F7_MULDIV, ONES, ONES, 0)));
        dir.push_back(chk(mk(OPC_OP, 3'd3, F7_MULDIV, ONES, ONES, 0)));
        dir.push_back(chk(mk(OPC_OPIMM, F3_SR, 7'h20, MIN64, 0, 0)));
        dir.push_back(chk(mk(OPC_OPIMM, F3_SLL, 7'h02, 64'd1, 0, 0)));
        dir.push_back(chk(mk(OPC_OPIMM32, F3_SR, F7_ALT, 64'h8000_0000, 0, 0)));
        dir.push_back(chk(mk(OPC_OP, F3_SR, F7_ALT, MIN64, 64'hff, 0)));
        dir.push_back(chk(mk(OPC_OP32, F3_SLL, 7'h00, 64'd1, 64'h3f, 0)));
        dir.push_back(chk(mk(OPC_JALR, 3'd0, 0, 64'd7, 0, 32'hffff_ffff)));
        dir.push_back(fix(mk(OPC_JALR, 3'd1, 0, 64'd7, 0, 0),
                          wb_t'{1'b1, 64'h1000, 64'd0, 1'b0, 5'd5}));
        dir.push_back(chk(mk(OPC_BRANCH, F3_BLT, 0, MIN64, 64'd0, 32'h8000_0000)));
        dir.push_back(chk(mk(OPC_BRANCH, 3'd2, 0, 0, 0, 32'd8)));
        dir.push_back(fix(mk(OPC_LUI, 0, 0, 0, 0, 32'h7fff_f000),
                          wb_t'{1'b0, 64'h1004, 64'h7fff_f000, 1'b1, 5'd5}));
        dir.push_back(fix(mk(4'd15, 0, 0, 0, 0, 0),
                          wb_t'{1'b1, 64'h1000, 64'd0, 1'b0, 5'd5}));
        t = mk(OPC_JAL, 0, 0, 0, 0, 32'd16);
        t.rd = 0; t.len = 3'd7; t.pc = ONES;
        dir.push_back(chk(t));
        foreach (dir[i]) send_insn(dir[i].t, dir[i].fixed, dir[i].exp);
        for (int n = 0; n < 1400; n++) send_insn(rand_insn(), 1'b0, '0);
        s_axis_tvalid <= 1'b0;
        drive_done = 1;
    end

    // sink: random stalls plus one long hold-off to back the queue up
    initial begin
        m_axis_tready = 0;
        @(posedge i_rst_n);
        repeat (300) @(posedge i_clk);
        hold_sink = 1;
        repeat (400) @(posedge i_clk);
        hold_sink = 0;
    end

    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            if (hold_sink) begin
                m_axis_tready <= 1'b0;
                while (hold_sink) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        wb_t got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = wb_t'(m_axis_tdata[134:0]);
            if (wb_expected.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected item %h", got);
            end else begin
                want = wb_expected.pop_front();
                if (got !== want) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch rd %0d/%0d we %b/%b val %h/%h npc %h/%h ill %b/%b",
                                 want.rd, got.rd, want.we, got.we, want.val, got.val,
                                 want.npc, got.npc, want.ill, got.ill);
                end
            end
        end
    end

    initial begin
        wait (drive_done);
        wait (wb_expected.size() == 0);
        repeat (200) @(posedge i_clk);
        if (n_mismatch == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
